>>> rtl/core/sgm_pkg.sv
package sgm_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 10;
    localparam int RAD_W   = 22;
    localparam int MAG_W   = 11;
    localparam int ROW_W   = 10;
    localparam int OUT_C_W = 10;
    localparam int CFG_W   = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int NRES    = 4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_OUT
    } state_t;

    // line store access from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ls_ctrl_t;

    // 1-2-1 weighted sum
    function automatic logic [SUM_W-1:0] wsum(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    function automatic logic [SUM_W-1:0] absdiff(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

>>> rtl/core/sobel_gradient_magnitude.sv
// path: a result is offered after its pixel transfer goes through states READ, GRAD, SQUARE and ROOT
// pixels: a new pixel is taken only in IDLE, after all results the last one causes (0 to 4) are sent,
// so the pace is set by one shared 11-step iterative square root and the line store read
// reset: asynchronous active low; counters and window cleared, width and height 512
// line store contents are undefined after reset and need no clearing pass
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // pixel stream in
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sgm_pkg::PIX_W-1:0]     pixel,
    // result stream out
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sgm_pkg::MAG_W-1:0]     magnitude,
    output logic [sgm_pkg::ROW_W-1:0]     out_row,
    output logic [sgm_pkg::OUT_C_W-1:0]   out_col,
    output logic                          last_of_run,
    output logic                          end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [sgm_pkg::CFG_W-1:0] width_reg;
    logic [sgm_pkg::CFG_W-1:0] height_reg;
    logic                      cfg_wr;

    // last valid column and row after clamping
    logic [CW-1:0]             wlast;
    logic [sgm_pkg::ROW_W-1:0] hlast;

    sgm_pkg::state_t state_reg, state_next;

    // next pixel position
    logic [CW-1:0]             col_reg;
    logic [sgm_pkg::ROW_W-1:0] row_reg;
    logic [CW-1:0]             cur_c_reg;
    logic [sgm_pkg::ROW_W-1:0] cur_r_reg;
    logic [CW-1:0]             c_eff;
    logic [sgm_pkg::ROW_W-1:0] r_eff;
    logic [sgm_pkg::PIX_W-1:0] px_reg;

    // pending results of the current pixel, one bit each
    // bit k: k[1] picks the lower row pair, k[0] the right column pair
    logic [sgm_pkg::NRES-1:0]  mask_reg;
    logic [sgm_pkg::NRES-1:0]  mask_new;
    logic [sgm_pkg::NRES-1:0]  cur_bit;
    logic [1:0]                k;

    logic [sgm_pkg::PIX_W-1:0] win_reg [3][3];
    logic [sgm_pkg::PIX_W-1:0] s [3][3];
    logic [1:0]                ri [3];
    logic [1:0]                cj [3];

    logic [sgm_pkg::SUM_W-1:0] gh_reg, gv_reg;
    logic [sgm_pkg::MAG_W-1:0] mag_reg;

    // line store
    sgm_pkg::ls_ctrl_t           ls_ctrl;
    logic [CW-1:0]               ls_addr;
    logic [2*sgm_pkg::PIX_W-1:0] ls_wdata;
    logic [2*sgm_pkg::PIX_W-1:0] ls_rdata;
    logic [sgm_pkg::PIX_W-1:0]   mid_px;
    logic [sgm_pkg::PIX_W-1:0]   top_px;
    logic                        rowend;
    logic                        lastrow;

    // square root unit
    logic                        sq_start;
    logic [sgm_pkg::RAD_W-1:0]   sq_rad;
    logic                        sq_done;
    logic [sgm_pkg::MAG_W-1:0]   sq_root;
    logic [2*sgm_pkg::SUM_W-1:0] gh_sq, gv_sq;

    logic in_xfer;
    logic out_xfer;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sgm_pkg::CFG_W'(512);
            height_reg <= sgm_pkg::CFG_W'(512);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == sgm_pkg::REG_WIDTH)
            begin
                width_reg <= pwdata[sgm_pkg::CFG_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[sgm_pkg::CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == sgm_pkg::REG_HEIGHT) ?
                    {{(32 - sgm_pkg::CFG_W){1'b0}}, height_reg} :
                    {{(32 - sgm_pkg::CFG_W){1'b0}}, width_reg};

    // zero acts as one, oversize clamps to the limit
    always_comb
    begin
        if (width_reg == '0)
        begin
            wlast = '0;
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            wlast = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = CW'(width_reg - sgm_pkg::CFG_W'(1));
        end

        if (height_reg == '0)
        begin
            hlast = '0;
        end
        else if (int'(height_reg) > sgm_pkg::HEIGHT_LIMIT)
        begin
            hlast = sgm_pkg::ROW_W'(sgm_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            hlast = sgm_pkg::ROW_W'(height_reg - sgm_pkg::CFG_W'(1));
        end
    end

    // counters beyond a shrunk limit restart the row or frame
    assign c_eff = (col_reg > wlast) ? '0 : col_reg;
    assign r_eff = (row_reg > hlast) ? '0 : row_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign in_xfer  = in_valid & ~in_stall;
    assign out_xfer = out_valid & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        sq_start   = 1'b0;
        ls_ctrl    = '0;
        case (state_reg)
            sgm_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                ls_ctrl.rd_en = in_valid;
                if (in_valid)
                begin
                    state_next = sgm_pkg::ST_READ;
                end
            end
            sgm_pkg::ST_READ:
            begin
                ls_ctrl.wr_en = 1'b1;
                state_next = (mask_new != '0) ? sgm_pkg::ST_GRAD : sgm_pkg::ST_IDLE;
            end
            sgm_pkg::ST_GRAD:
            begin
                state_next = sgm_pkg::ST_SQUARE;
            end
            sgm_pkg::ST_SQUARE:
            begin
                sq_start   = 1'b1;
                state_next = sgm_pkg::ST_ROOT;
            end
            sgm_pkg::ST_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = sgm_pkg::ST_OUT;
                end
            end
            sgm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = last_of_run ? sgm_pkg::ST_IDLE : sgm_pkg::ST_GRAD;
                end
            end
            default:
            begin
                state_next = sgm_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // line store read, modify, write back
    // ---------------------------------------------------------------
    assign ls_addr  = (state_reg == sgm_pkg::ST_IDLE) ? c_eff : cur_c_reg;
    assign mid_px   = (cur_r_reg >= sgm_pkg::ROW_W'(1)) ?
                      ls_rdata[sgm_pkg::PIX_W-1:0] : px_reg;
    assign top_px   = (cur_r_reg >= sgm_pkg::ROW_W'(2)) ?
                      ls_rdata[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W] : mid_px;
    assign ls_wdata = {mid_px, px_reg};

    sgm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .ctrl    (ls_ctrl),
        .addr    (ls_addr),
        .wr_data (ls_wdata),
        .rd_data (ls_rdata)
    );

    assign rowend  = (cur_c_reg == wlast);
    assign lastrow = (cur_r_reg == hlast);

    // which results this pixel releases, including the bottom row and right column ones
    always_comb
    begin
        mask_new[0] = (cur_r_reg != '0) && (cur_c_reg != '0);
        mask_new[1] = (cur_r_reg != '0) && rowend;
        mask_new[2] = lastrow && (cur_c_reg != '0);
        mask_new[3] = lastrow && rowend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            mask_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            if (state_reg == sgm_pkg::ST_READ)
            begin
                mask_reg <= mask_new;
                if (rowend)
                begin
                    col_reg <= '0;
                    row_reg <= lastrow ? '0 : cur_r_reg + sgm_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= cur_c_reg + CW'(1);
                end
                // first column fills the window by replication
                if (cur_c_reg == '0)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        win_reg[0][j] <= top_px;
                        win_reg[1][j] <= mid_px;
                        win_reg[2][j] <= px_reg;
                    end
                end
                else
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        win_reg[0][j] <= win_reg[0][j+1];
                        win_reg[1][j] <= win_reg[1][j+1];
                        win_reg[2][j] <= win_reg[2][j+1];
                    end
                    win_reg[0][2] <= top_px;
                    win_reg[1][2] <= mid_px;
                    win_reg[2][2] <= px_reg;
                end
            end
            else if (out_xfer)
            begin
                mask_reg <= mask_reg & ~cur_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg    <= pixel;
            cur_c_reg <= c_eff;
            cur_r_reg <= r_eff;
        end
    end

    // ---------------------------------------------------------------
    // gradient, square root, result
    // ---------------------------------------------------------------
    assign cur_bit = mask_reg & (~mask_reg + sgm_pkg::NRES'(1));

    always_comb
    begin
        k = 2'd3;
        if (mask_reg[0])
        begin
            k = 2'd0;
        end
        else if (mask_reg[1])
        begin
            k = 2'd1;
        end
        else if (mask_reg[2])
        begin
            k = 2'd2;
        end
    end

    // bottom row or right column results reuse the edge pixels
    assign ri[0] = k[1] ? 2'd1 : 2'd0;
    assign ri[1] = k[1] ? 2'd2 : 2'd1;
    assign ri[2] = 2'd2;
    assign cj[0] = k[0] ? 2'd1 : 2'd0;
    assign cj[1] = k[0] ? 2'd2 : 2'd1;
    assign cj[2] = 2'd2;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s[i][j] = win_reg[ri[i]][cj[j]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sgm_pkg::ST_GRAD)
        begin
            gh_reg <= sgm_pkg::absdiff(sgm_pkg::wsum(s[0][0], s[0][1], s[0][2]),
                                       sgm_pkg::wsum(s[2][0], s[2][1], s[2][2]));
            gv_reg <= sgm_pkg::absdiff(sgm_pkg::wsum(s[0][0], s[1][0], s[2][0]),
                                       sgm_pkg::wsum(s[0][2], s[1][2], s[2][2]));
        end
        if (sq_done)
        begin
            mag_reg <= sq_root;
        end
    end

    assign gh_sq  = gh_reg * gh_reg;
    assign gv_sq  = gv_reg * gv_reg;
    assign sq_rad = sgm_pkg::RAD_W'(gh_sq) + sgm_pkg::RAD_W'(gv_sq);

    sgm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign magnitude    = mag_reg;
    assign out_row      = k[1] ? cur_r_reg : cur_r_reg - sgm_pkg::ROW_W'(1);
    assign out_col      = sgm_pkg::OUT_C_W'(k[0] ? cur_c_reg : cur_c_reg - CW'(1));
    assign last_of_run  = (mask_reg == cur_bit);
    assign end_of_frame = (k == 2'd3);

endmodule

>>> rtl/core/sgm_line_store.sv
module sgm_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        clk,
    input  sgm_pkg::ls_ctrl_t           ctrl,
    input  logic [AW-1:0]               addr,
    input  logic [2*sgm_pkg::PIX_W-1:0] wr_data,
    output logic [2*sgm_pkg::PIX_W-1:0] rd_data
);

    // each entry: {row r-2, row r-1}
    logic [2*sgm_pkg::PIX_W-1:0] mem [DEPTH];
    logic [2*sgm_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sgm_isqrt.sv
module sgm_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sgm_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [sgm_pkg::MAG_W-1:0]   root
);

    localparam int REM_W = sgm_pkg::MAG_W + 3;

    logic [sgm_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [sgm_pkg::MAG_W-1:0] root_reg, root_next;
    logic [3:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          trial;

    // two radicand bits per step, one root bit
    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[sgm_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[sgm_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[sgm_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[sgm_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(sgm_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/sgm_checker.sv
module sgm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sgm_pkg::MAG_W-1:0]     magnitude,
    input logic                          last_of_run,
    input logic                          end_of_frame
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // no pixel taken while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("pixel taken during result delivery");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("frame end not last of run");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> magnitude <= sgm_pkg::MAG_W'(1443))
        else $error("magnitude out of range");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .magnitude    (magnitude),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
);

>>> tb/sobel_gradient_magnitude_tb.sv
module sobel_gradient_magnitude_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 1024;
    // cycles the block may still be busy after the last expected transfer
    localparam int SETTLE_CYCLES = 4 + sgm_pkg::MAG_W + 4 * 15 + 20;
    localparam int HOLD_CYCLES = 300;

    // one result transfer, in port order
    typedef struct {
        logic [sgm_pkg::MAG_W-1:0]   mag;
        logic [sgm_pkg::ROW_W-1:0]   row;
        logic [sgm_pkg::OUT_C_W-1:0] col;
        logic                        last;
        logic                        eof;
    } edge_result_t;

    // running model of the filter plus the queue of magnitudes still owed
    class sobel_scoreboard;
        int unsigned    width_reg;
        int unsigned    height_reg;
        int unsigned    row;
        int unsigned    col;
        bit [7:0]       line_above[LINE_DEPTH];
        bit [7:0]       line_two_above[LINE_DEPTH];
        bit [7:0]       win[9];
        edge_result_t   owed[$];
        int             errors;

        function new();
            width_reg = 512;
            height_reg = 512;
            row = 0;
            col = 0;
            errors = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            return (height_reg > sgm_pkg::HEIGHT_LIMIT) ? sgm_pkg::HEIGHT_LIMIT : height_reg;
        endfunction

        function void write_reg(logic idx, logic [sgm_pkg::CFG_W-1:0] value);
            if (idx == sgm_pkg::REG_WIDTH)
                width_reg = value;
            else
                height_reg = value;
        endfunction

        // sobel on a chosen view of the window; rows/cols pick replicated edges
        function int unsigned grad_mag(int rt, int rm, int rb, int cl, int cc, int cr);
            int top, bot, lft, rgt, gh, gv;
            int unsigned sq, root;
            top = win[rt*3+cl] + 2 * win[rt*3+cc] + win[rt*3+cr];
            bot = win[rb*3+cl] + 2 * win[rb*3+cc] + win[rb*3+cr];
            lft = win[rt*3+cl] + 2 * win[rm*3+cl] + win[rb*3+cl];
            rgt = win[rt*3+cr] + 2 * win[rm*3+cr] + win[rb*3+cr];
            gh = (top > bot) ? top - bot : bot - top;
            gv = (lft > rgt) ? lft - rgt : rgt - lft;
            sq = gh * gh + gv * gv;
            root = 0;
            while ((root + 1) * (root + 1) <= sq)
                root++;
            return root;
        endfunction

        function void owe(int unsigned mag, int unsigned r, int unsigned c, bit eof);
            edge_result_t e;
            e.mag = mag[sgm_pkg::MAG_W-1:0];
            e.row = r[sgm_pkg::ROW_W-1:0];
            e.col = c[sgm_pkg::OUT_C_W-1:0];
            e.last = 1'b0;
            e.eof = eof;
            owed.insert(owed.size(), e);
        endfunction

        function void note_pixel(logic [sgm_pkg::PIX_W-1:0] px);
            int unsigned w, h, r, c, start;
            bit [7:0] mid, top;
            bit lastrow, rowend;
            w = eff_width();
            h = eff_height();
            if (row >= h) row = 0;
            if (col >= w) col = 0;
            r = row;
            c = col;
            mid = (r >= 1) ? line_above[c] : px;
            top = (r >= 2) ? line_two_above[c] : mid;
            line_two_above[c] = mid;
            line_above[c] = px;
            if (c == 0) begin
                for (int k = 0; k < 3; k++) begin
                    win[k] = top;
                    win[3+k] = mid;
                    win[6+k] = px;
                end
            end else begin
                for (int k = 0; k < 2; k++) begin
                    win[k] = win[k+1];
                    win[3+k] = win[3+k+1];
                    win[6+k] = win[6+k+1];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = px;
            end
            lastrow = (r == h - 1);
            rowend = (c == w - 1);
            start = owed.size();
            if (r >= 1) begin
                if (c >= 1) owe(grad_mag(0, 1, 2, 0, 1, 2), r - 1, c - 1, 0);
                if (rowend) owe(grad_mag(0, 1, 2, 1, 2, 2), r - 1, c, 0);
            end
            if (lastrow) begin
                if (c >= 1) owe(grad_mag(1, 2, 2, 0, 1, 2), r, c - 1, 0);
                if (rowend) owe(grad_mag(1, 2, 2, 1, 2, 2), r, c, 1);
            end
            if (owed.size() > start)
                owed[owed.size()-1].last = 1'b1;
            if (rowend) begin
                col = 0;
                row = lastrow ? 0 : r + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        task check_result(edge_result_t got);
            edge_result_t e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
                return;
            end
            e = owed.pop_front();
            if (got.mag !== e.mag)
                report($sformatf("magnitude %0d, wanted %0d (row %0d col %0d)",
                                 got.mag, e.mag, e.row, e.col));
            if (got.row !== e.row)
                report($sformatf("out_row %0d, wanted %0d", got.row, e.row));
            if (got.col !== e.col)
                report($sformatf("out_col %0d, wanted %0d", got.col, e.col));
            if (got.last !== e.last)
                report($sformatf("last_of_run %0b, wanted %0b (row %0d col %0d)",
                                 got.last, e.last, e.row, e.col));
            if (got.eof !== e.eof)
                report($sformatf("end_of_frame %0b, wanted %0b (row %0d col %0d)",
                                 got.eof, e.eof, e.row, e.col));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [2:0]                  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [sgm_pkg::PIX_W-1:0]   pixel = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [sgm_pkg::MAG_W-1:0]   magnitude;
    logic [sgm_pkg::ROW_W-1:0]   out_row;
    logic [sgm_pkg::OUT_C_W-1:0] out_col;
    logic                        last_of_run;
    logic                        end_of_frame;

    // idle percentages for each side, changed per phase
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // long receiver hold-off, requested by the stimulus and counted below
    bit          hold_go = 1'b0;
    int unsigned hold_left = 0;
    int unsigned sent = 0;

    sobel_scoreboard sb = new();

    sobel_gradient_magnitude dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .magnitude    (magnitude),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // result monitor: sampled mid-cycle, the transfer lands on the next rising edge
    always @(negedge clk)
    begin
        edge_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mag = magnitude;
            got.row = out_row;
            got.col = out_col;
            got.last = last_of_run;
            got.eof = end_of_frame;
            sb.check_result(got);
        end
    end

    // wait for every owed result, then let the pipeline go quiet
    task automatic drain();
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle then access cycle, upper data bits random
    task automatic write_reg(logic idx, int unsigned value);
        logic [31:0] data;
        data = $urandom();
        data[sgm_pkg::CFG_W-1:0] = value[sgm_pkg::CFG_W-1:0];
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, data[sgm_pkg::CFG_W-1:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering pixels, let the block empty, then resize
    task automatic set_size(int unsigned w, int unsigned h);
        in_valid <= 1'b0;
        drain();
        write_reg(sgm_pkg::REG_WIDTH, w);
        write_reg(sgm_pkg::REG_HEIGHT, h);
    endtask

    // one pixel transfer, with a random gap in front of it
    task automatic send_pixel(logic [sgm_pkg::PIX_W-1:0] px);
        bit taken;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        sb.note_pixel(px);
        sent++;
    endtask

    task automatic send_frame(int unsigned w, int unsigned h);
        set_size(w, h);
        for (int unsigned i = 0; i < sb.eff_width() * sb.eff_height(); i++)
            send_pixel($urandom_range(0, 255));
    endtask

    // random small frames until the phase has sent its share
    task automatic random_frames(int unsigned quota);
        int unsigned stop_at;
        stop_at = sent + quota;
        while (sent < stop_at)
            send_frame($urandom_range(1, 8), $urandom_range(1, 6));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: checkerboard on a 3x3 frame
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hff : 8'h00);
        // zero size acts as a single pixel frame
        set_size(0, 0);
        send_pixel(8'hff);
        send_pixel(8'h00);
        // one column frame, replication on both sides
        set_size(1, 4);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'hff);
        send_pixel(8'h00);
        // 2x2 with a hard vertical edge, then a flat bright frame
        set_size(2, 2);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'hff);
        send_pixel(8'hff);
        send_pixel(8'hff);
        send_pixel(8'hff);

        // width shrinks part way through a row: the row restarts at column 0
        set_size(6, 5);
        for (int i = 0; i < 15; i++)
            send_pixel($urandom_range(0, 255));
        in_valid <= 1'b0;
        drain();
        write_reg(sgm_pkg::REG_WIDTH, 3);
        while (sb.row != 0 || sb.col != 0)
            send_pixel($urandom_range(0, 255));

        // sender sometimes idle, receiver mostly stalled
        tx_idle_pct = 33;
        rx_idle_pct = 87;
        random_frames(40);

        // sender mostly idle, receiver sometimes stalled
        tx_idle_pct = 87;
        rx_idle_pct = 33;
        random_frames(40);

        // full rate, with one long hold-off so the block backs up its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_size(8, 6);
        hold_go = 1'b1;
        for (int i = 0; i < 48; i++)
            send_pixel($urandom_range(0, 255));
        random_frames(30);

        in_valid <= 1'b0;
        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
